// ===== design/halftone_disk_dot_renderer_defines.svh =====
// Assertion macros shared by the halftone disk dot renderer queue and back end.
`ifndef HALFTONE_DISK_DOT_RENDERER_DEFINES_SVH
`define HALFTONE_DISK_DOT_RENDERER_DEFINES_SVH

// ante implies cons on the same edge; clock and reset are the module's own.
`define HDDR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hddr: implication check failed");

// expr must never be true outside reset.
`define HDDR_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("hddr: forbidden condition seen");

`endif

// ===== design/hddr_pkg.sv =====
// Shared constants and types of the halftone disk dot renderer.
package hddr_pkg;

   localparam int CELL_PITCH_DEFAULT  = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int WEIGHT_W = 8;
   localparam int COORD_W  = 8;
   localparam int SCREEN_W = 11;
   localparam int PIXEL_W  = 24;
   localparam int LEVEL_W  = 5;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [1:0] CSR_IDX_RED   = 2'd0;
   localparam logic [1:0] CSR_IDX_GREEN = 2'd1;
   localparam logic [1:0] CSR_IDX_BLUE  = 2'd2;

   localparam logic [WEIGHT_W-1:0] WGT_RED_RESET   = 8'd77;
   localparam logic [WEIGHT_W-1:0] WGT_GREEN_RESET = 8'd150;
   localparam logic [WEIGHT_W-1:0] WGT_BLUE_RESET  = 8'd29;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
   } item_type;

   typedef struct packed {
      logic head_valid;
      logic almost_full;
      logic full;
   } queue_status_type;

endpackage

// ===== design/hddr_front.sv =====
// Front end: takes a pixel, forms luma and the disk size level, pushes to the queue.
module hddr_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [hddr_pkg::WEIGHT_W-1:0]  wgt_red,
   input  logic [hddr_pkg::WEIGHT_W-1:0]  wgt_green,
   input  logic [hddr_pkg::WEIGHT_W-1:0]  wgt_blue,
   input  logic                           start,
   output logic                           busy,
   input  logic [hddr_pkg::PIXEL_W-1:0]   pixel_rgb,
   input  logic [hddr_pkg::COORD_W-1:0]   cell_x,
   input  logic [hddr_pkg::COORD_W-1:0]   cell_y,
   input  hddr_pkg::queue_status_type     q_status,
   output logic                           push,
   output hddr_pkg::item_type             push_item
);
   import hddr_pkg::*;

   logic                 stg_v_ff, stg_v_in;
   logic [15:0]          prod_r_ff, prod_g_ff, prod_b_ff;
   logic [COORD_W-1:0]   cx_ff, cy_ff;
   logic                 accept;
   logic [17:0]          sum;
   logic [9:0]           luma_raw;
   logic [7:0]           luma;

   // a word in the product stage still needs a slot
   assign busy   = stg_v_ff ? q_status.almost_full : q_status.full;
   assign accept = start && !busy;
   assign stg_v_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff <= 1'b0;
      end else begin
         stg_v_ff <= stg_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_r_ff <= wgt_red   * pixel_rgb[23:16];
         prod_g_ff <= wgt_green * pixel_rgb[15:8];
         prod_b_ff <= wgt_blue  * pixel_rgb[7:0];
         cx_ff     <= cell_x;
         cy_ff     <= cell_y;
      end
   end

   always_comb begin
      sum      = 18'(prod_r_ff) + 18'(prod_g_ff) + 18'(prod_b_ff);
      luma_raw = sum[17:8];
      luma     = (|luma_raw[9:8]) ? 8'hff : luma_raw[7:0];
   end

   assign push             = stg_v_ff;
   assign push_item.level  = luma[7:3];
   assign push_item.cell_x = cx_ff;
   assign push_item.cell_y = cy_ff;

endmodule

// ===== design/hddr_queue.sv =====
// Short item queue between the front end and the raster back end.
`include "halftone_disk_dot_renderer_defines.svh"
module hddr_queue #(
   parameter int DEPTH = hddr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  hddr_pkg::item_type          push_item,
   input  logic                        pop,
   output hddr_pkg::item_type          head_item,
   output hddr_pkg::queue_status_type  q_status
);
   import hddr_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PTR_W = $clog2(DEPTH);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item            = slot_ff[rd_ptr_ff];
   assign q_status.head_valid  = (count_ff != '0);
   assign q_status.almost_full = (count_ff >= CNT_W'(DEPTH - 1));
   assign q_status.full        = (count_ff == CNT_W'(DEPTH));

   `HDDR_ASSERT_NEVER(a_queue_no_overflow, push && count_ff == CNT_W'(DEPTH))
   `HDDR_ASSERT_NEVER(a_queue_no_underflow, pop && count_ff == '0)

endmodule

// ===== design/hddr_back.sv =====
// Back end: walks the disk raster, counts covered subsamples, drives result words.
`include "halftone_disk_dot_renderer_defines.svh"
module hddr_back #(
   parameter int CELL_PITCH = hddr_pkg::CELL_PITCH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hddr_pkg::queue_status_type     q_status,
   input  hddr_pkg::item_type             head_item,
   output logic                           pop,
   output logic                           out_strobe,
   output logic [hddr_pkg::SCREEN_W-1:0]  out_screen_x,
   output logic [hddr_pkg::SCREEN_W-1:0]  out_screen_y,
   output logic [hddr_pkg::PIXEL_W-1:0]   out_gray_pixel,
   output logic                           out_last
);
   import hddr_pkg::*;

   localparam int HALF  = CELL_PITCH / 2;
   localparam int SIDE  = 2 * HALF - 1;
   localparam int CNT_W = $clog2(SIDE + 1);
   localparam int LIM_W = 16 + $clog2(HALF * HALF + 1);
   localparam int CMP_W = (LIM_W > 20) ? LIM_W : 20;

   localparam logic [CNT_W-1:0] CTR_POS  = CNT_W'(HALF - 1);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(SIDE - 1);

   // issue stage: raster position of the current disk
   logic                 act_ff, act_in;
   logic [CNT_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic [LIM_W-1:0]     lim_ff, lim_in;
   logic [COORD_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic                 at_last;
   logic [7:0]           base;

   // compare stage
   logic                 cmp_v_ff;
   logic [15:0]          hit_ff, hit_in;
   logic [SCREEN_W-1:0]  sx_ff, sy_ff;
   logic                 last_ff;

   // output stage
   logic                 out_v_ff;
   logic [SCREEN_W-1:0]  out_x_ff, out_y_ff;
   logic [PIXEL_W-1:0]   out_gray_ff;
   logic                 out_last_ff;

   logic [CNT_W-1:0]     dy_full, dx_full;
   logic [1:0]           dy, dx;
   logic [3:0]           cov;
   int                   ones;

   assign at_last = (row_ff == LAST_POS) && (col_ff == LAST_POS);
   assign pop     = q_status.head_valid && (!act_ff || at_last);
   assign base    = 8'd128 + 8'(head_item.level);

   always_comb begin
      act_in = act_ff;
      row_in = row_ff;
      col_in = col_ff;
      lim_in = lim_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      if (pop) begin
         act_in = 1'b1;
         row_in = '0;
         col_in = '0;
         lim_in = LIM_W'(LIM_W'(16'(base * base)) * LIM_W'(HALF * HALF));
         cx_in  = head_item.cell_x;
         cy_in  = head_item.cell_y;
      end else if (act_ff) begin
         if (at_last) begin
            act_in = 1'b0;
         end else if (col_ff == LAST_POS) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      lim_ff <= lim_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
   end

   // 4x4 subsample disk test
   always_comb begin
      logic [3:0]       p, q;
      logic [8:0]       s;
      logic [CMP_W-1:0] d;
      dy_full = (row_ff > CTR_POS) ? row_ff - CTR_POS : CTR_POS - row_ff;
      dx_full = (col_ff > CTR_POS) ? col_ff - CTR_POS : CTR_POS - col_ff;
      dy      = 2'(dy_full);
      dx      = 2'(dx_full);
      hit_in  = '0;
      for (int u = 0; u < 4; u++) begin
         for (int v = 0; v < 4; v++) begin
            p = {dy, 2'(u)};
            q = {dx, 2'(v)};
            s = 9'(8'(p * p)) + 9'(8'(q * q));
            d = CMP_W'(CMP_W'(s) * CMP_W'(1600));
            hit_in[u * 4 + v] = (d < CMP_W'(lim_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_v_ff <= 1'b0;
      end else begin
         cmp_v_ff <= act_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      sx_ff   <= SCREEN_W'(SCREEN_W'(cx_ff) * SCREEN_W'(CELL_PITCH) + SCREEN_W'(col_ff));
      sy_ff   <= SCREEN_W'(SCREEN_W'(cy_ff) * SCREEN_W'(CELL_PITCH) + SCREEN_W'(row_ff));
      last_ff <= at_last;
   end

   always_comb begin
      ones = $countones(hit_ff);
      cov  = (ones > 15) ? 4'hf : 4'(ones);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= cmp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff    <= sx_ff;
      out_y_ff    <= sy_ff;
      out_gray_ff <= {cov, 4'h0, cov, 4'h0, cov, 4'h0};
      out_last_ff <= last_ff;
   end

   assign out_strobe     = out_v_ff;
   assign out_screen_x   = out_x_ff;
   assign out_screen_y   = out_y_ff;
   assign out_gray_pixel = out_gray_ff;
   assign out_last       = out_v_ff && out_last_ff;

   `HDDR_ASSERT_IMP(a_back_raster_range, act_ff, (row_ff <= LAST_POS) && (col_ff <= LAST_POS))
   `HDDR_ASSERT_IMP(a_back_run_ends_on_last, $fell(out_v_ff), $past(out_last_ff))

endmodule

// ===== design/halftone_disk_dot_renderer.sv =====
// Top level of the halftone disk dot renderer: register port and module wiring.
// Each word taken on start expands into a run of (2*(CELL_PITCH/2)-1)^2 gray
// result words, 49 at the default CELL_PITCH of 8, one per clock, in row order,
// rsp_last marking the final one. The back end's raster counter issues one
// disk pixel per cycle; runs of consecutive items follow each other with no
// gap. The receiver cannot stall: rsp_strobe marks each result for exactly one
// cycle. A word passes the product stage, the queue, the raster issue stage,
// the compare stage and the output stage before its first result reaches the
// ports. Up to QUEUE_DEPTH words wait in a queue ahead of the raster; busy is
// high while it has no room. The user must write luma weights over the register
// port only while the block is idle; the block itself does not enforce it.
module halftone_disk_dot_renderer #(
   parameter int CELL_PITCH  = hddr_pkg::CELL_PITCH_DEFAULT,
   parameter int QUEUE_DEPTH = hddr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [hddr_pkg::PIXEL_W-1:0]   req_pixel_rgb,
   input  logic [hddr_pkg::COORD_W-1:0]   req_cell_x,
   input  logic [hddr_pkg::COORD_W-1:0]   req_cell_y,
   output logic                           rsp_strobe,
   output logic [hddr_pkg::SCREEN_W-1:0]  rsp_screen_x,
   output logic [hddr_pkg::SCREEN_W-1:0]  rsp_screen_y,
   output logic [hddr_pkg::PIXEL_W-1:0]   rsp_gray_pixel,
   output logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hddr_pkg::CSR_AW-1:0]    paddr,
   input  logic [hddr_pkg::CSR_DW-1:0]    pwdata,
   output logic [hddr_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);
   import hddr_pkg::*;

   logic [WEIGHT_W-1:0] wgt_red_ff, wgt_green_ff, wgt_blue_ff;
   logic                csr_wr;
   logic [1:0]          csr_idx;

   queue_status_type    q_status;
   item_type            push_item, head_item;
   logic                push, pop;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wgt_red_ff   <= WGT_RED_RESET;
         wgt_green_ff <= WGT_GREEN_RESET;
         wgt_blue_ff  <= WGT_BLUE_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_RED:   wgt_red_ff   <= pwdata[WEIGHT_W-1:0];
            CSR_IDX_GREEN: wgt_green_ff <= pwdata[WEIGHT_W-1:0];
            CSR_IDX_BLUE:  wgt_blue_ff  <= pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_RED:   prdata = CSR_DW'(wgt_red_ff);
         CSR_IDX_GREEN: prdata = CSR_DW'(wgt_green_ff);
         CSR_IDX_BLUE:  prdata = CSR_DW'(wgt_blue_ff);
         default:       prdata = '0;
      endcase
   end

   hddr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .wgt_red   (wgt_red_ff),
      .wgt_green (wgt_green_ff),
      .wgt_blue  (wgt_blue_ff),
      .start     (start),
      .busy      (busy),
      .pixel_rgb (req_pixel_rgb),
      .cell_x    (req_cell_x),
      .cell_y    (req_cell_y),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   hddr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   hddr_back #(
      .CELL_PITCH (CELL_PITCH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_item      (head_item),
      .pop            (pop),
      .out_strobe     (rsp_strobe),
      .out_screen_x   (rsp_screen_x),
      .out_screen_y   (rsp_screen_y),
      .out_gray_pixel (rsp_gray_pixel),
      .out_last       (rsp_last)
   );

endmodule

// ===== sim/halftone_disk_dot_renderer_checker.sv =====
// Checker for the halftone disk dot renderer: predicts each run of gray words and compares.
`timescale 1ns / 1ps
module halftone_disk_dot_renderer_checker #(
   parameter int CELL_PITCH = hddr_pkg::CELL_PITCH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [hddr_pkg::PIXEL_W-1:0]   req_pixel_rgb,
   input  logic [hddr_pkg::COORD_W-1:0]   req_cell_x,
   input  logic [hddr_pkg::COORD_W-1:0]   req_cell_y,
   input  logic                           rsp_strobe,
   input  logic [hddr_pkg::SCREEN_W-1:0]  rsp_screen_x,
   input  logic [hddr_pkg::SCREEN_W-1:0]  rsp_screen_y,
   input  logic [hddr_pkg::PIXEL_W-1:0]   rsp_gray_pixel,
   input  logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hddr_pkg::CSR_AW-1:0]    paddr,
   input  logic [hddr_pkg::CSR_DW-1:0]    pwdata,
   input  logic                           pready,
   output int unsigned                    pending_words,
   output int unsigned                    fail_count
);
   import hddr_pkg::*;

   localparam int HALF = CELL_PITCH / 2;
   localparam int SIDE = 2 * HALF - 1;

   typedef struct packed {
      logic [SCREEN_W-1:0] screen_x;
      logic [SCREEN_W-1:0] screen_y;
      logic [PIXEL_W-1:0]  gray_pixel;
      logic                last;
   } gray_word_type;

   gray_word_type gray_expect_q[$];
   int unsigned wgt_red   = WGT_RED_RESET;
   int unsigned wgt_green = WGT_GREEN_RESET;
   int unsigned wgt_blue  = WGT_BLUE_RESET;
   int unsigned queued_words = 0;
   int unsigned mismatch_total = 0;

   assign pending_words = queued_words;
   assign fail_count    = mismatch_total;

   // subsamples of one pixel inside the disk, clamped to 15
   function automatic logic [3:0] disk_coverage(int unsigned dy, int unsigned dx,
                                                int unsigned level);
      int unsigned limit_sq, hits, p, q, u, v;
      limit_sq = HALF * HALF * (128 + level) * (128 + level);
      hits = 0;
      for (u = 0; u < 4; u++) begin
         p = 4 * dy + u;
         for (v = 0; v < 4; v++) begin
            q = 4 * dx + v;
            if (1600 * (p * p + q * q) < limit_sq) hits++;
         end
      end
      return (hits > 15) ? 4'd15 : hits[3:0];
   endfunction

   task automatic predict_disk_run(input logic [PIXEL_W-1:0] rgb,
                                   input logic [COORD_W-1:0] cx,
                                   input logic [COORD_W-1:0] cy);
      int unsigned   luma, level, row, col, dy, dx;
      logic [3:0]    c;
      gray_word_type w;
      luma = (wgt_red * int'(rgb[23:16]) + wgt_green * int'(rgb[15:8])
              + wgt_blue * int'(rgb[7:0])) >> 8;
      if (luma > 255) luma = 255;
      level = luma >> 3;
      for (row = 0; row < SIDE; row++) begin
         dy = (row > HALF - 1) ? row - (HALF - 1) : (HALF - 1) - row;
         for (col = 0; col < SIDE; col++) begin
            dx = (col > HALF - 1) ? col - (HALF - 1) : (HALF - 1) - col;
            c = disk_coverage(dy, dx, level);
            w.screen_x   = SCREEN_W'(int'(cx) * CELL_PITCH + col);
            w.screen_y   = SCREEN_W'(int'(cy) * CELL_PITCH + row);
            w.gray_pixel = {c, 4'h0, c, 4'h0, c, 4'h0};
            w.last       = (row == SIDE - 1) && (col == SIDE - 1);
            gray_expect_q.push_back(w);
         end
      end
   endtask

   always @(posedge clock) begin
      gray_word_type want;
      if (reset) begin
         wgt_red   = WGT_RED_RESET;
         wgt_green = WGT_GREEN_RESET;
         wgt_blue  = WGT_BLUE_RESET;
         gray_expect_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               CSR_IDX_RED:   wgt_red   = pwdata[7:0];
               CSR_IDX_GREEN: wgt_green = pwdata[7:0];
               CSR_IDX_BLUE:  wgt_blue  = pwdata[7:0];
               default: ;
            endcase
         end
         if (start && !busy) predict_disk_run(req_pixel_rgb, req_cell_x, req_cell_y);
         if (rsp_strobe) begin
            if (gray_expect_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("unexpected word: x=%0d y=%0d gray=%06h last=%0b",
                           rsp_screen_x, rsp_screen_y, rsp_gray_pixel, rsp_last);
            end else begin
               want = gray_expect_q.pop_front();
               if (want.screen_x !== rsp_screen_x || want.screen_y !== rsp_screen_y ||
                   want.gray_pixel !== rsp_gray_pixel || want.last !== rsp_last) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display("mismatch: expected x=%0d y=%0d gray=%06h last=%0b,",
                              want.screen_x, want.screen_y, want.gray_pixel, want.last,
                              " got x=%0d y=%0d gray=%06h last=%0b",
                              rsp_screen_x, rsp_screen_y, rsp_gray_pixel, rsp_last);
               end
            end
         end
      end
      queued_words <= gray_expect_q.size();
   end

endmodule

// ===== sim/halftone_disk_dot_renderer_tb.sv =====
// Testbench top for the halftone disk dot renderer: stimulus, register writes, verdict.
`timescale 1ns / 1ps
module halftone_disk_dot_renderer_tb;
   import hddr_pkg::*;

   localparam int CELL_PITCH  = CELL_PITCH_DEFAULT;
   localparam int BLOCK_COUNT = 8;
   localparam int BLOCK_WORDS = 51;
   localparam logic [1:0] CSR_IDX_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [PIXEL_W-1:0]    req_pixel_rgb = '0;
   logic [COORD_W-1:0]    req_cell_x = '0;
   logic [COORD_W-1:0]    req_cell_y = '0;
   logic                  rsp_strobe;
   logic [SCREEN_W-1:0]   rsp_screen_x;
   logic [SCREEN_W-1:0]   rsp_screen_y;
   logic [PIXEL_W-1:0]    rsp_gray_pixel;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_AW-1:0]     paddr = '0;
   logic [CSR_DW-1:0]     pwdata = '0;
   logic [CSR_DW-1:0]     prdata;
   logic                  pready;
   int unsigned           pending_words;
   int unsigned           fail_count;
   int unsigned           sender_idle_pct = 0;

   halftone_disk_dot_renderer #(.CELL_PITCH(CELL_PITCH)) i_dut (.*);

   halftone_disk_dot_renderer_checker #(.CELL_PITCH(CELL_PITCH)) i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_word(input logic [PIXEL_W-1:0] rgb, input logic [COORD_W-1:0] cx,
                            input logic [COORD_W-1:0] cy);
      int unsigned gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_pixel_rgb <= rgb;
      req_cell_x    <= cx;
      req_cell_y    <= cy;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // lowers start and holds off until every predicted word has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [WEIGHT_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_weights(input logic [WEIGHT_W-1:0] wr, input logic [WEIGHT_W-1:0] wg,
                              input logic [WEIGHT_W-1:0] wb);
      wait_drained();
      csr_write(CSR_IDX_RED, wr);
      csr_write(CSR_IDX_GREEN, wg);
      csr_write(CSR_IDX_BLUE, wb);
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel();
      logic [7:0] v;
      v = 8'($urandom);
      case ($urandom_range(5))
         0: return {v, v, v};
         1: return {8'hff, 8'($urandom), 8'h00};
         2: return {8'h00, v, 8'hff};
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned blk, n;
      int unsigned idle_plan[3];
      idle_plan = '{0, 52, 32};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset weights: black, white, primaries, coordinate extremes
      send_word(24'h000000, 8'd0, 8'd0);
      send_word(24'hffffff, 8'd255, 8'd255);
      send_word(24'hff0000, 8'd0, 8'd255);
      send_word(24'h00ff00, 8'd255, 8'd0);
      send_word(24'h0000ff, 8'd17, 8'd99);
      send_word(24'h808080, 8'd128, 8'd1);
      send_word(24'h7f7f7f, 8'd127, 8'd127);
      send_word(24'ha55a3c, 8'd200, 8'd64);

      // full weights saturate luma for bright pixels
      set_weights(8'd255, 8'd255, 8'd255);
      send_word(24'hffffff, 8'd3, 8'd4);
      send_word(24'h010101, 8'd5, 8'd6);
      send_word(24'h808080, 8'd7, 8'd8);
      send_word(24'h000000, 8'd9, 8'd10);

      // zero weights, then a write to an unused index must change nothing
      set_weights(8'd0, 8'd0, 8'd0);
      send_word(24'hffffff, 8'd11, 8'd12);
      wait_drained();
      csr_write(CSR_IDX_UNUSED, 8'hff);
      send_word(24'hffffff, 8'd13, 8'd14);

      set_weights(8'd255, 8'd0, 8'd0);
      send_word(24'hff0000, 8'd15, 8'd16);
      send_word(24'h00ffff, 8'd17, 8'd18);

      for (blk = 0; blk < BLOCK_COUNT; blk++) begin
         case ($urandom_range(3))
            0: set_weights(8'($urandom), 8'($urandom), 8'($urandom));
            1: set_weights(8'd255, 8'($urandom), 8'($urandom));
            2: set_weights(8'($urandom_range(60)), 8'($urandom_range(60)),
                           8'($urandom_range(60)));
            default: set_weights(WGT_RED_RESET, WGT_GREEN_RESET, WGT_BLUE_RESET);
         endcase
         sender_idle_pct = idle_plan[blk % 3];
         for (n = 0; n < BLOCK_WORDS; n++) begin
            if ($urandom_range(39) == 0) wait_drained();
            send_word(random_pixel(), 8'($urandom), 8'($urandom));
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
